// ===== rtl/core/ipdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_pkg: shared types and constants of the distance follower
// Register map, drive mode codes, fixed widths and the output scaling
// constants used by the PID stage, the drive stage and the checker.
// ----------------------------------------------------------------------------
package ipdf_pkg;

    // Field widths
    localparam int DIST_W  = 13;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 14;
    localparam int ACC_W   = 32;
    localparam int CLAMP_W = 11;
    localparam int SPEED_W = 10;
    localparam int MODE_W  = 2;

    // Register indexes (byte address 4*index)
    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_TARGET   = 3'd3;
    localparam logic [2:0] REG_DEADBAND = 3'd4;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_P_RESET   = 16'sd1280;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RESET   = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RESET   = 16'sd0;
    localparam logic [DIST_W-1:0]        TARGET_RESET   = 13'd150;
    localparam logic [DIST_W-1:0]        DEADBAND_RESET = 13'd10;

    // Drive mode codes
    localparam logic [MODE_W-1:0] MODE_STOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BACKWARD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

    // Output clamp and base speed
    localparam logic signed [CLAMP_W-1:0] OUT_LIMIT  = 11'sd1000;
    localparam logic signed [SPEED_W-1:0] BASE_SPEED = 10'sd100;

    // x/5 for x <= 2000 as (x * 52429) >> 18, exact over that range
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
    } gains_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [SPEED_W-1:0] speed;
        logic signed [CLAMP_W-1:0] clamped;
    } result_t;

endpackage

// ===== rtl/core/ipdf_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_pid: incremental PID step
// Forms the new error and the updated, saturated integer accumulator from
// one distance, the gains and the two previous errors.
// ----------------------------------------------------------------------------
module ipdf_pid
(
    input  logic [ipdf_pkg::DIST_W-1:0]        distance,
    input  logic [ipdf_pkg::DIST_W-1:0]        target,
    input  ipdf_pkg::gains_t                   gains,
    input  logic signed [ipdf_pkg::ERR_W-1:0]  last_err,
    input  logic signed [ipdf_pkg::ERR_W-1:0]  prior_err,
    input  logic signed [ipdf_pkg::ACC_W-1:0]  acc,
    output logic signed [ipdf_pkg::ERR_W-1:0]  err_new,
    output logic signed [ipdf_pkg::ACC_W-1:0]  acc_new
);

    logic signed [14:0] d_err;      // e - e1
    logic signed [16:0] dd_err;     // e - 2*e1 + e2
    logic signed [30:0] prod_p;
    logic signed [29:0] prod_i;
    logic signed [32:0] prod_d;
    logic signed [34:0] incr;
    logic signed [40:0] total;
    logic signed [32:0] shifted;
    logic signed [32:0] quot;
    logic               round_up;

    // Error and its differences
    assign err_new = $signed({1'b0, target}) - $signed({1'b0, distance});
    assign d_err   = 15'(err_new) - 15'(last_err);
    assign dd_err  = 17'(err_new) - (17'(last_err) <<< 1) + 17'(prior_err);

    // Three gain products, summed in units of 1/256
    assign prod_p = 31'(gains.gain_p) * 31'(d_err);
    assign prod_i = 30'(gains.gain_i) * 30'(err_new);
    assign prod_d = 33'(gains.gain_d) * 33'(dd_err);
    assign incr   = 35'(prod_p) + 35'(prod_i) + 35'(prod_d);

    // acc*256 + increment, divided by 256 toward zero
    assign total    = (41'(acc) <<< 8) + 41'(incr);
    assign shifted  = 33'(total >>> 8);
    assign round_up = total[40] & (|total[7:0]);
    assign quot     = shifted + $signed({32'd0, round_up});

    // Saturate to the 32-bit range
    always_comb
    begin
        if (quot[32] == quot[31])
        begin
            acc_new = quot[31:0];
        end
        else if (!quot[32])
        begin
            acc_new = {1'b0, {(ipdf_pkg::ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_new = {1'b1, {(ipdf_pkg::ACC_W-1){1'b0}}};
        end
    end

endmodule

// ===== rtl/core/ipdf_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_drive: output clamp, 0.4 scaling and drive choice
// Clamps the accumulator to +/-1000, scales it by 2/5 toward zero and
// picks stop, forward or backward from the error and the dead band.
// ----------------------------------------------------------------------------
module ipdf_drive
(
    input  logic signed [ipdf_pkg::ACC_W-1:0] acc,
    input  logic signed [ipdf_pkg::ERR_W-1:0] err,
    input  logic [ipdf_pkg::DIST_W-1:0]       dead_band,
    output ipdf_pkg::result_t                 res
);

    logic signed [ipdf_pkg::CLAMP_W-1:0] clamped;
    logic signed [ipdf_pkg::CLAMP_W-1:0] mag_s;
    logic [9:0]                          mag;
    logic [10:0]                         twice;
    logic [26:0]                         prod;
    logic [8:0]                          quot;
    logic signed [ipdf_pkg::SPEED_W-1:0] scaled;
    logic signed [14:0]                  err_x;
    logic signed [14:0]                  band;

    // Clamp
    always_comb
    begin
        if (acc > 32'(ipdf_pkg::OUT_LIMIT))
        begin
            clamped = ipdf_pkg::OUT_LIMIT;
        end
        else if (acc < -32'(ipdf_pkg::OUT_LIMIT))
        begin
            clamped = -ipdf_pkg::OUT_LIMIT;
        end
        else
        begin
            clamped = acc[ipdf_pkg::CLAMP_W-1:0];
        end
    end

    // |x|*2/5 by reciprocal, sign put back afterwards (truncation toward zero)
    assign mag_s  = clamped[ipdf_pkg::CLAMP_W-1] ? -clamped : clamped;
    assign mag    = mag_s[9:0];
    assign twice  = {mag, 1'b0};
    assign prod   = 27'(twice) * 27'(ipdf_pkg::DIV5_RECIP);
    assign quot   = prod[26:ipdf_pkg::DIV5_SHIFT];
    assign scaled = clamped[ipdf_pkg::CLAMP_W-1] ? -$signed({1'b0, quot})
                                                 : $signed({1'b0, quot});

    // Dead band decision
    assign err_x = 15'(err);
    assign band  = $signed({2'b00, dead_band});

    always_comb
    begin
        res.clamped = clamped;
        if (err_x < -band)
        begin
            res.mode  = ipdf_pkg::MODE_FORWARD;
            res.speed = ipdf_pkg::BASE_SPEED + scaled;
        end
        else if (err_x > band)
        begin
            res.mode  = ipdf_pkg::MODE_BACKWARD;
            res.speed = -ipdf_pkg::BASE_SPEED - scaled;
        end
        else
        begin
            res.mode  = ipdf_pkg::MODE_STOP;
            res.speed = '0;
        end
    end

endmodule

// ===== rtl/core/incremental_pid_distance_follower.sv =====
`timescale 1ns / 1ps
// An accepted input item passes the input register, the PID stage registers and
// the result register to m_axis. Throughput: one item per cycle unless m_axis_tready
// stalls; the PID stage closes its accumulator and error feedback loop combinationally.
// Reset: rst_n clears all valid flags and the error and accumulator state to
// zero, and loads the register reset values (gain_p 5.0, target 150, band 10).
// ----------------------------------------------------------------------------
// incremental_pid_distance_follower: top level
// Input register, PID stage holding the controller state, and a result
// register fed by the clamp/scale/drive logic, with an APB register port.
// ----------------------------------------------------------------------------
module incremental_pid_distance_follower
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [12:0] measured_distance, [15:13] zero
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [10:0] clamped_output, [20:11] wheel_speed,
                                        // [22:21] drive_mode, [23] zero
);

    ipdf_pkg::gains_t                   gains_reg;
    logic [ipdf_pkg::DIST_W-1:0]        target_reg;
    logic [ipdf_pkg::DIST_W-1:0]        band_reg;

    logic                               in_valid_reg;
    logic [ipdf_pkg::DIST_W-1:0]        dist_reg;
    logic                               pid_valid_reg;
    logic signed [ipdf_pkg::ERR_W-1:0]  last_err_reg;
    logic signed [ipdf_pkg::ERR_W-1:0]  prior_err_reg;
    logic signed [ipdf_pkg::ACC_W-1:0]  acc_reg;
    logic                               out_valid_reg;
    ipdf_pkg::result_t                  res_reg;

    logic signed [ipdf_pkg::ERR_W-1:0]  err_next;
    logic signed [ipdf_pkg::ACC_W-1:0]  acc_next;
    ipdf_pkg::result_t                  res_next;
    logic                               cfg_write;
    logic                               out_load;
    logic                               pid_load;
    logic                               in_load;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.gain_p <= ipdf_pkg::GAIN_P_RESET;
            gains_reg.gain_i <= ipdf_pkg::GAIN_I_RESET;
            gains_reg.gain_d <= ipdf_pkg::GAIN_D_RESET;
            target_reg       <= ipdf_pkg::TARGET_RESET;
            band_reg         <= ipdf_pkg::DEADBAND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                ipdf_pkg::REG_GAIN_P:   gains_reg.gain_p <= pwdata[15:0];
                ipdf_pkg::REG_GAIN_I:   gains_reg.gain_i <= pwdata[15:0];
                ipdf_pkg::REG_GAIN_D:   gains_reg.gain_d <= pwdata[15:0];
                ipdf_pkg::REG_TARGET:   target_reg       <= pwdata[12:0];
                ipdf_pkg::REG_DEADBAND: band_reg         <= pwdata[12:0];
                default:                ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (paddr[4:2])
            ipdf_pkg::REG_GAIN_P:   prdata = 32'(gains_reg.gain_p);
            ipdf_pkg::REG_GAIN_I:   prdata = 32'(gains_reg.gain_i);
            ipdf_pkg::REG_GAIN_D:   prdata = 32'(gains_reg.gain_d);
            ipdf_pkg::REG_TARGET:   prdata = {19'd0, target_reg};
            ipdf_pkg::REG_DEADBAND: prdata = {19'd0, band_reg};
            default:                prdata = '0;
        endcase
    end

    // Stage flow: each stage loads when empty or when its item moves on
    assign out_load      = ~out_valid_reg | m_axis_tready;
    assign pid_load      = ~pid_valid_reg | out_load;
    assign in_load       = ~in_valid_reg | pid_load;
    assign s_axis_tready = in_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && s_axis_tvalid)
        begin
            dist_reg <= s_axis_tdata[ipdf_pkg::DIST_W-1:0];
        end
    end

    // PID stage: controller state advances once per item
    ipdf_pid u_pid
    (
        .distance  (dist_reg),
        .target    (target_reg),
        .gains     (gains_reg),
        .last_err  (last_err_reg),
        .prior_err (prior_err_reg),
        .acc       (acc_reg),
        .err_new   (err_next),
        .acc_new   (acc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_valid_reg <= 1'b0;
            last_err_reg  <= '0;
            prior_err_reg <= '0;
            acc_reg       <= '0;
        end
        else if (pid_load)
        begin
            pid_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                prior_err_reg <= last_err_reg;
                last_err_reg  <= err_next;
                acc_reg       <= acc_next;
            end
        end
    end

    // Drive stage into the result register
    ipdf_drive u_drive
    (
        .acc       (acc_reg),
        .err       (last_err_reg),
        .dead_band (band_reg),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= pid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && pid_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.mode, res_reg.speed, res_reg.clamped};

endmodule

// ===== rtl/core/ipdf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_checker: port-level checks of the distance follower
// Watches the result stream for held items and consistent result fields.
// ----------------------------------------------------------------------------
module ipdf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    logic signed [ipdf_pkg::CLAMP_W-1:0] clamped;
    logic signed [ipdf_pkg::SPEED_W-1:0] speed;
    logic [ipdf_pkg::MODE_W-1:0]         mode;

    assign clamped = m_axis_tdata[10:0];
    assign speed   = m_axis_tdata[20:11];
    assign mode    = m_axis_tdata[22:21];

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The spare mode code never appears
    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> mode != ipdf_pkg::MODE_UNUSED)
        else $error("unused drive mode");

    // Stopping means zero speed
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && mode == ipdf_pkg::MODE_STOP |-> speed == '0)
        else $error("non-zero speed while stopped");

    // Clamped output and speed stay within their limits
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> clamped <= ipdf_pkg::OUT_LIMIT && clamped >= -ipdf_pkg::OUT_LIMIT
                          && speed <= 10'sd500 && speed >= -10'sd500)
        else $error("result out of range");

endmodule

bind incremental_pid_distance_follower ipdf_checker u_ipdf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/incremental_pid_distance_follower_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// incremental_pid_distance_follower_tb: self-checking bench of the follower
// Streams ranger distances through the block under several register settings.
// Each result is checked against a local incremental PID predictor. Covers
// the dead band edges, the output clamp and extreme gains and distances,
// with random gaps on the input and output streams.
// ----------------------------------------------------------------------------
module incremental_pid_distance_follower_tb;

    localparam int DIST_MAX    = (1 << ipdf_pkg::DIST_W) - 1;
    localparam int ACC_MAX     = 32'sh7fffffff;
    localparam int ACC_MIN     = -ACC_MAX - 1;
    localparam int SETTLE      = 8;
    localparam int RANDOM_GOAL = 1200;
    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [12:0] measured_distance, [15:13] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;     // [10:0] clamped_output, [20:11] wheel_speed,
                                   // [22:21] drive_mode, [23] zero

    incremental_pid_distance_follower dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor copy of the registers and controller state
    int kp, ki, kd, tgt, band;
    int err_last, err_prior, acc;

    logic [ipdf_pkg::DIST_W-1:0] distance_q[$];
    ipdf_pkg::result_t           drive_q[$];

    int   in_gap, out_stall;
    int   calm[2];
    logic in_fire;

    int cycles, items_in, results_out, mismatches, unexpected;
    int reg_writes, settings_used, random_items;
    int sat_hi, sat_lo;
    int mode_seen[3];

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Incremental PID step: updates the error history and accumulator and
    // returns the result the block should give for this distance
    function automatic ipdf_pkg::result_t pid_step(input logic [ipdf_pkg::DIST_W-1:0] distance);
        int                e, lim, scaled, speed;
        longint            inc, total;
        ipdf_pkg::result_t r;
        e = tgt - int'(distance);
        inc = longint'(kp) * (e - err_last) + longint'(ki) * e
            + longint'(kd) * (e - 2 * err_last + err_prior);
        err_prior = err_last;
        err_last  = e;
        // exact sum in 1/256 units, then truncation toward zero
        total = (longint'(acc) * 256 + inc) / 256;
        if (total > ACC_MAX)
        begin
            total = ACC_MAX;
            sat_hi++;
        end
        if (total < ACC_MIN)
        begin
            total = ACC_MIN;
            sat_lo++;
        end
        acc = int'(total);
        lim = acc;
        if (lim > int'(ipdf_pkg::OUT_LIMIT))
            lim = ipdf_pkg::OUT_LIMIT;
        if (lim < -int'(ipdf_pkg::OUT_LIMIT))
            lim = -int'(ipdf_pkg::OUT_LIMIT);
        scaled = (lim * 2) / 5;
        if (e < -band)
        begin
            r.mode = ipdf_pkg::MODE_FORWARD;
            speed  = int'(ipdf_pkg::BASE_SPEED) + scaled;
        end
        else if (e > band)
        begin
            r.mode = ipdf_pkg::MODE_BACKWARD;
            speed  = -int'(ipdf_pkg::BASE_SPEED) - scaled;
        end
        else
        begin
            r.mode = ipdf_pkg::MODE_STOP;
            speed  = 0;
        end
        r.clamped = lim[ipdf_pkg::CLAMP_W-1:0];
        r.speed   = speed[ipdf_pkg::SPEED_W-1:0];
        return r;
    endfunction

    // Idle length: mostly none, a few long; calm stretches have no idling
    function automatic int next_gap(input int side);
        int r;
        if (calm[side] > 0)
        begin
            calm[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm[side] = $urandom_range(20, 100);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(16, 40);
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2, 3: return 0;
            default: return int'($urandom_range(0, 3072)) - 1536;
        endcase
    endfunction

    // Distances mostly around the target and the dead band edges
    function automatic logic [ipdf_pkg::DIST_W-1:0] pick_distance();
        int r, w, d;
        r = $urandom_range(0, 99);
        w = band + 60;
        if (r < 60)
            d = tgt + int'($urandom_range(0, 2 * w)) - w;
        else if (r < 80)
            d = $urandom_range(0, DIST_MAX);
        else if (r < 88)
            d = ($urandom_range(0, 1) != 0) ? DIST_MAX : 0;
        else
        begin
            case ($urandom_range(0, 3))
                0: d = tgt - band;
                1: d = tgt + band;
                2: d = tgt - band - 1;
                default: d = tgt + band + 1;
            endcase
        end
        if (d < 0)
            d = 0;
        if (d > DIST_MAX)
            d = DIST_MAX;
        return d[ipdf_pkg::DIST_W-1:0];
    endfunction

    // APB write: setup then access; predictor follows once accepted
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ipdf_pkg::REG_GAIN_P:   kp = $signed(value[ipdf_pkg::GAIN_W-1:0]);
            ipdf_pkg::REG_GAIN_I:   ki = $signed(value[ipdf_pkg::GAIN_W-1:0]);
            ipdf_pkg::REG_GAIN_D:   kd = $signed(value[ipdf_pkg::GAIN_W-1:0]);
            ipdf_pkg::REG_TARGET:   tgt = value[ipdf_pkg::DIST_W-1:0];
            ipdf_pkg::REG_DEADBAND: band = value[ipdf_pkg::DIST_W-1:0];
            default: ;    // unmapped address, no effect
        endcase
        reg_writes++;
    endtask

    // Junk in the unused upper bits of every write
    task automatic load_settings(input int p, input int i, input int d,
                                 input int t, input int b);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(ipdf_pkg::REG_GAIN_P, {junk[31:16], p[15:0]});
        junk = $urandom;
        reg_write(ipdf_pkg::REG_GAIN_I, {junk[31:16], i[15:0]});
        junk = $urandom;
        reg_write(ipdf_pkg::REG_GAIN_D, {junk[31:16], d[15:0]});
        junk = $urandom;
        reg_write(ipdf_pkg::REG_TARGET, {junk[31:13], t[12:0]});
        junk = $urandom;
        reg_write(ipdf_pkg::REG_DEADBAND, {junk[31:13], b[12:0]});
        settings_used++;
    endtask

    // Wait until every queued item has gone in and come out, then settle
    task automatic drain();
        while (distance_q.size() != 0 || s_axis_tvalid || drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Input driver, also driving the result side ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fire)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (distance_q.size() != 0)
                begin
                    s_axis_tdata  <= {3'b000, distance_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    in_gap = next_gap(0);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            // result side back-pressure
            if (out_stall > 0)
            begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                out_stall = next_gap(1);
            end
        end
    end

    // Monitor: predict on each accepted item, check each result
    always @(posedge clk)
    begin
        ipdf_pkg::result_t want, got;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                drive_q.push_back(pid_step(s_axis_tdata[ipdf_pkg::DIST_W-1:0]));
                items_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[22:0];
                results_out++;
                if (drive_q.size() == 0)
                begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("[%0t] result with nothing expected: out %0d speed %0d mode %0d",
                                 $realtime, got.clamped, got.speed, got.mode);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (want.mode <= ipdf_pkg::MODE_BACKWARD)
                        mode_seen[want.mode]++;
                    if (got.clamped !== want.clamped || got.speed !== want.speed ||
                        got.mode !== want.mode)
                    begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display({"[%0t] result %0d: out %0d/%0d speed %0d/%0d ",
                                      "mode %0d/%0d (exp/got)"},
                                     $realtime, results_out, want.clamped, got.clamped,
                                     want.speed, got.speed, want.mode, got.mode);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, drive_q.size());
            $display("incremental_pid_distance_follower_tb failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int n;
        logic [31:0] junk;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        in_gap        = 0;
        out_stall     = 0;
        calm[0]       = 0;
        calm[1]       = 0;
        kp   = ipdf_pkg::GAIN_P_RESET;
        ki   = ipdf_pkg::GAIN_I_RESET;
        kd   = ipdf_pkg::GAIN_D_RESET;
        tgt  = ipdf_pkg::TARGET_RESET;
        band = ipdf_pkg::DEADBAND_RESET;
        err_last  = 0;
        err_prior = 0;
        acc       = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: dead band edges, range extremes
        distance_q = '{150, 140, 139, 160, 161, 0, DIST_MAX, DIST_MAX, 0, 150,
                       4096, 2730, 5461, 1, DIST_MAX - 1};
        drain();

        // Extreme gains, no dead band; unmapped addresses must do nothing
        load_settings(32767, -32768, 32767, DIST_MAX, 0);
        for (int k = ipdf_pkg::REG_DEADBAND + 1; k < 8; k++)
        begin
            junk = $urandom;
            reg_write(k[2:0], junk);
        end
        distance_q = '{0, DIST_MAX, 0, DIST_MAX, DIST_MAX, 0};
        drain();

        // Opposite extremes, widest dead band so every item stops
        load_settings(-32768, 32767, -32768, 0, DIST_MAX);
        distance_q = '{DIST_MAX, 0, DIST_MAX, 0};
        drain();

        // Random settings and distances
        while (random_items < RANDOM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0: n = 0;
                1: n = DIST_MAX;
                default: n = $urandom_range(0, DIST_MAX);
            endcase
            load_settings(pick_gain(), pick_gain(), pick_gain(), n,
                          ($urandom_range(0, 19) == 0) ? DIST_MAX :
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 300));
            n = $urandom_range(60, 140);
            for (int k = 0; k < n; k++)
                distance_q.push_back(pick_distance());
            random_items += n;
            drain();
        end

        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE * 2) @(posedge clk);

        $display("%0d distances in, %0d results out under %0d register settings (%0d writes)",
                 items_in, results_out, settings_used, reg_writes);
        $display("stop/forward/backward %0d/%0d/%0d, accumulator pinned high %0d, low %0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], sat_hi, sat_lo);
        if (mismatches == 0 && unexpected == 0 && drive_q.size() == 0)
            $display("incremental_pid_distance_follower_tb passed");
        else
            $display("incremental_pid_distance_follower_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ipdf_pkg.sv
rtl/core/ipdf_pid.sv
rtl/core/ipdf_drive.sv
rtl/core/incremental_pid_distance_follower.sv
rtl/core/ipdf_checker.sv
tb/incremental_pid_distance_follower_tb.sv
